// ===== hw/rtl/hash_table_overflow_chaining_macros.svh =====
// Assertion macros for the hash table block.
// Included by hash_table_overflow_chaining.sv; needs clk and rst in scope.
`ifndef HASH_TABLE_OVERFLOW_CHAINING_MACROS_SVH
`define HASH_TABLE_OVERFLOW_CHAINING_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define HTOC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define HTOC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/htoc_pkg.sv =====
// Shared constants for the hash table with overflow chaining.
// No dependencies.
package htoc_pkg;

  localparam int NUM_BUCKETS_DEF      = 64;
  localparam int SLOTS_PER_BUCKET_DEF = 2;
  localparam int POOL_RECORDS_DEF     = 64;

  localparam int CMD_W  = 2;
  localparam int KEY_W  = 31;
  localparam int VAL_W  = 32;
  localparam int STAT_W = 2;
  localparam int LOC_W  = 8;
  localparam int ACC_W  = 7;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;

  // Status codes
  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [STAT_W-1:0] STAT_POOL_FULL = 2'd2;

endpackage

// ===== hw/rtl/hash_table_overflow_chaining.sv =====
// Keyed record store with fixed bucket slots and a chained overflow pool.
// Depends on htoc_pkg and hash_table_overflow_chaining_macros.svh.
//
// Usage: after reset the block runs a clearing pass over both memories with
// busy high. Raise start with cmd, key and value while busy is low; busy
// rises and the item runs alone until one result shows on status, location,
// found_value and accesses for a single cycle with done high. The receiver
// cannot stall, so take the result in that cycle. An item reduces the key to
// a bucket (reciprocal multiply, then remainder) and fetches the bucket row.
// An insert into an unused bucket takes slot 0; an insert into a bucket with
// a chain goes straight to the free-record scan. Otherwise the bucket slots
// are checked in turn; then an insert scans the pool for a free record and a
// search or delete walks the chain, with a memory read on each link. A delete
// unlinks a chained record it finds, or refills a freed slot from the chain
// head. The result strobe comes in the cycle after the last busy cycle.
`include "hash_table_overflow_chaining_macros.svh"

module hash_table_overflow_chaining #(
  parameter int NUM_BUCKETS      = htoc_pkg::NUM_BUCKETS_DEF,
  parameter int SLOTS_PER_BUCKET = htoc_pkg::SLOTS_PER_BUCKET_DEF,
  parameter int POOL_RECORDS     = htoc_pkg::POOL_RECORDS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [htoc_pkg::CMD_W-1:0]     cmd,
  input  logic [htoc_pkg::KEY_W-1:0]     key,
  input  logic signed [htoc_pkg::VAL_W-1:0] value,
  output logic                           done,
  output logic [htoc_pkg::STAT_W-1:0]    status,
  output logic [htoc_pkg::LOC_W-1:0]     location,
  output logic signed [htoc_pkg::VAL_W-1:0] found_value,
  output logic [htoc_pkg::ACC_W-1:0]     accesses
);

  localparam int KW  = htoc_pkg::KEY_W;
  localparam int VW  = htoc_pkg::VAL_W;
  localparam int BW  = $clog2(NUM_BUCKETS);
  localparam int PW  = $clog2(POOL_RECORDS);
  localparam int S   = SLOTS_PER_BUCKET;
  localparam int SIW = (S > 1) ? $clog2(S) : 1;
  localparam int MAIN_SLOTS = NUM_BUCKETS * S;
  localparam int CLR_N = (NUM_BUCKETS > POOL_RECORDS) ? NUM_BUCKETS : POOL_RECORDS;
  localparam int CLW = $clog2(CLR_N);
  localparam int PRW = KW + VW;
  localparam int MSH = KW + BW;
  localparam logic [63:0] RECIP_W =
    ((64'd1 << MSH) + 64'(NUM_BUCKETS) - 64'd1) / 64'(NUM_BUCKETS);
  localparam logic [VW-1:0] RECIP = VW'(RECIP_W);
  localparam logic [BW-1:0] NB_LOW = BW'(NUM_BUCKETS);
  localparam logic [PW:0] CHAIN_END = {(PW+1){1'b1}};
  localparam logic [PW:0] POOL_N = (PW+1)'(POOL_RECORDS);
  localparam logic [SIW-1:0] LAST_SLOT = SIW'(S - 1);
  localparam logic [PW-1:0] LAST_REC = PW'(POOL_RECORDS - 1);
  localparam logic [CLW-1:0] LAST_CLR = CLW'(CLR_N - 1);

  typedef struct packed {
    logic          valid;
    logic [KW-1:0] key;
    logic [VW-1:0] val;
  } slot_t;

  typedef struct packed {
    logic          used;
    logic [PW:0]   head;
    slot_t [S-1:0] slots;
  } row_t;

  typedef struct packed {
    logic          valid;
    logic [KW-1:0] key;
    logic [VW-1:0] val;
    logic [PW:0]   nxt;
  } rec_t;

  typedef enum logic [13:0] {
    ST_CLEAR  = 14'b00000000000001,
    ST_IDLE   = 14'b00000000000010,
    ST_HASH   = 14'b00000000000100,
    ST_MOD    = 14'b00000000001000,
    ST_BRD    = 14'b00000000010000,
    ST_CAP    = 14'b00000000100000,
    ST_DECIDE = 14'b00000001000000,
    ST_SLOT   = 14'b00000010000000,
    ST_FREE   = 14'b00000100000000,
    ST_WISSUE = 14'b00001000000000,
    ST_WCHK   = 14'b00010000000000,
    ST_UNLINK = 14'b00100000000000,
    ST_DREF   = 14'b01000000000000,
    ST_DREFC  = 14'b10000000000000
  } state_t;

  // Memories: bucket rows and pool records
  row_t bmem [NUM_BUCKETS];
  rec_t pmem [POOL_RECORDS];
  row_t bmem_q;
  rec_t pmem_q;

  logic          bwe;
  logic [BW-1:0] bwa;
  row_t          bwd;
  logic          pwe;
  logic [PW-1:0] pwa;
  rec_t          pwd;
  logic [PW-1:0] pra;

  // Control and item registers
  state_t state, state_next;
  logic [htoc_pkg::CMD_W-1:0] cmd_q, cmd_next;
  logic [KW-1:0] key_q, key_next;
  logic [VW-1:0] val_q, val_next;
  logic [PRW-1:0] prod, prod_next;
  logic [BW-1:0] bucket, bucket_next;
  row_t row, row_next;
  logic [SIW-1:0] sidx, sidx_next;
  logic [htoc_pkg::ACC_W-1:0] acc, acc_next;
  logic [PW:0] iss, iss_next;
  logic [PW-1:0] chk, chk_next;
  logic chk_ok, chk_ok_next;
  logic [PW:0] p, p_next;
  logic [PW:0] prev, prev_next;
  rec_t prev_rec, prev_rec_next;
  logic [PW:0] nxt_q, nxt_q_next;
  logic [PW:0] w, w_next;
  logic [CLW-1:0] clr, clr_next;

  logic done_next;
  logic [htoc_pkg::STAT_W-1:0] status_next;
  logic [htoc_pkg::LOC_W-1:0] location_next;
  logic [VW-1:0] found_next;
  logic [htoc_pkg::ACC_W-1:0] acc_out_next;

  logic [BW-1:0] q_low;
  logic [BW-1:0] rem_val;
  logic [htoc_pkg::ACC_W-1:0] acc_inc;
  slot_t cur_slot;
  logic [htoc_pkg::LOC_W-1:0] slot_loc;
  logic [htoc_pkg::LOC_W-1:0] rec_loc;
  logic [htoc_pkg::LOC_W-1:0] chk_loc;
  logic [PW:0] w_inc;

  assign busy = (state != ST_IDLE);

  // Bucket memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (bwe) begin
      bmem[bwa] <= bwd;
    end
    bmem_q <= bmem[bucket];
  end

  // Pool memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (pwe) begin
      pmem[pwa] <= pwd;
    end
    pmem_q <= pmem[pra];
  end

  // Remainder from the registered reciprocal product; only the low bits matter
  assign q_low   = prod[MSH +: BW];
  assign rem_val = key_q[BW-1:0] - q_low * NB_LOW;

  assign acc_inc  = acc + 1'b1;
  assign cur_slot = row.slots[sidx];
  assign slot_loc = htoc_pkg::LOC_W'(32'(bucket) * 32'(S) + 32'(sidx));
  assign rec_loc  = htoc_pkg::LOC_W'(32'(MAIN_SLOTS) + 32'(p));
  assign chk_loc  = htoc_pkg::LOC_W'(32'(MAIN_SLOTS) + 32'(chk));
  assign w_inc    = w + 1'b1;

  // Sequencer: next state, memory writes and result
  always_comb begin
    state_next    = state;
    cmd_next      = cmd_q;
    key_next      = key_q;
    val_next      = val_q;
    prod_next     = prod;
    bucket_next   = bucket;
    row_next      = row;
    sidx_next     = sidx;
    acc_next      = acc;
    iss_next      = iss;
    chk_next      = chk;
    chk_ok_next   = 1'b0;
    p_next        = p;
    prev_next     = prev;
    prev_rec_next = prev_rec;
    nxt_q_next    = nxt_q;
    w_next        = w;
    clr_next      = clr;
    done_next     = 1'b0;
    status_next   = status;
    location_next = location;
    found_next    = found_value;
    acc_out_next  = accesses;
    bwe = 1'b0;
    bwa = bucket;
    bwd = row;
    pwe = 1'b0;
    pwa = '0;
    pwd = pmem_q;
    pra = '0;

    unique case (state)
      ST_CLEAR: begin
        // Sweep both memories to their reset contents
        if (32'(clr) < NUM_BUCKETS) begin
          bwe = 1'b1;
          bwa = clr[BW-1:0];
          bwd = '0;
          bwd.head = CHAIN_END;
        end
        if (32'(clr) < POOL_RECORDS) begin
          pwe = 1'b1;
          pwa = clr[PW-1:0];
          pwd = '0;
        end
        clr_next = clr + 1'b1;
        if (clr == LAST_CLR) begin
          state_next = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (start) begin
          cmd_next    = cmd;
          key_next    = key;
          val_next    = value;
          bucket_next = '0;
          state_next  = ST_HASH;
        end
      end

      ST_HASH: begin
        // Multiply by the rounded-up reciprocal of the bucket count
        prod_next  = PRW'(key_q) * PRW'(RECIP);
        state_next = ST_MOD;
      end

      ST_MOD: begin
        bucket_next = rem_val;
        if (cmd_q == htoc_pkg::CMD_INSERT || cmd_q == htoc_pkg::CMD_SEARCH ||
            cmd_q == htoc_pkg::CMD_DELETE) begin
          state_next = ST_BRD;
        end else begin
          done_next     = 1'b1;
          status_next   = htoc_pkg::STAT_NOT_FOUND;
          location_next = '0;
          found_next    = '0;
          acc_out_next  = '0;
          state_next    = ST_IDLE;
        end
      end

      ST_BRD: begin
        state_next = ST_CAP;
      end

      ST_CAP: begin
        row_next   = bmem_q;
        sidx_next  = '0;
        acc_next   = '0;
        state_next = ST_DECIDE;
      end

      ST_DECIDE: begin
        priority if (cmd_q == htoc_pkg::CMD_INSERT && !row.used) begin
          // First insert into this bucket takes slot 0
          bwe = 1'b1;
          bwd = row;
          bwd.used = 1'b1;
          bwd.head = CHAIN_END;
          bwd.slots[0] = '{valid: 1'b1, key: key_q, val: val_q};
          done_next     = 1'b1;
          status_next   = htoc_pkg::STAT_OK;
          location_next = slot_loc;
          found_next    = '0;
          acc_out_next  = htoc_pkg::ACC_W'(1);
          state_next    = ST_IDLE;
        end else if (cmd_q == htoc_pkg::CMD_INSERT && row.head < POOL_N) begin
          iss_next   = '0;
          state_next = ST_FREE;
        end else if (cmd_q == htoc_pkg::CMD_SEARCH && !row.used) begin
          done_next     = 1'b1;
          status_next   = htoc_pkg::STAT_NOT_FOUND;
          location_next = '0;
          found_next    = '0;
          acc_out_next  = '0;
          state_next    = ST_IDLE;
        end else begin
          state_next = ST_SLOT;
        end
      end

      ST_SLOT: begin
        acc_next = acc_inc;
        priority if (cmd_q == htoc_pkg::CMD_INSERT) begin
          if (!cur_slot.valid) begin
            bwe = 1'b1;
            bwd = row;
            bwd.slots[sidx] = '{valid: 1'b1, key: key_q, val: val_q};
            done_next     = 1'b1;
            status_next   = htoc_pkg::STAT_OK;
            location_next = slot_loc;
            found_next    = '0;
            acc_out_next  = acc_inc;
            state_next    = ST_IDLE;
          end else if (sidx == LAST_SLOT) begin
            iss_next   = '0;
            state_next = ST_FREE;
          end else begin
            sidx_next = sidx + 1'b1;
          end
        end else if (cur_slot.valid && cur_slot.key == key_q) begin
          if (cmd_q == htoc_pkg::CMD_SEARCH) begin
            done_next     = 1'b1;
            status_next   = htoc_pkg::STAT_OK;
            location_next = slot_loc;
            found_next    = cur_slot.val;
            acc_out_next  = acc_inc;
            state_next    = ST_IDLE;
          end else if (row.head < POOL_N) begin
            // Refill the slot from the chain head
            state_next = ST_DREF;
          end else begin
            bwe = 1'b1;
            bwd = row;
            bwd.slots[sidx].valid = 1'b0;
            done_next     = 1'b1;
            status_next   = htoc_pkg::STAT_OK;
            location_next = slot_loc;
            found_next    = '0;
            acc_out_next  = '0;
            state_next    = ST_IDLE;
          end
        end else if (sidx == LAST_SLOT) begin
          // Walk the chain from its head
          p_next    = row.head;
          prev_next = CHAIN_END;
          w_next    = '0;
          if (row.head < POOL_N) begin
            state_next = ST_WISSUE;
          end else begin
            done_next     = 1'b1;
            status_next   = htoc_pkg::STAT_NOT_FOUND;
            location_next = '0;
            found_next    = '0;
            acc_out_next  = (cmd_q == htoc_pkg::CMD_SEARCH) ? acc_inc : '0;
            state_next    = ST_IDLE;
          end
        end else begin
          sidx_next = sidx + 1'b1;
        end
      end

      ST_FREE: begin
        // Pipelined scan: issue one record, check the one issued before
        pra         = (iss < POOL_N) ? iss[PW-1:0] : '0;
        iss_next    = iss + 1'b1;
        chk_next    = iss[PW-1:0];
        chk_ok_next = (iss < POOL_N);
        if (chk_ok) begin
          acc_next = acc_inc;
          if (!pmem_q.valid) begin
            pwe = 1'b1;
            pwa = chk;
            pwd = '{valid: 1'b1, key: key_q, val: val_q, nxt: row.head};
            bwe = 1'b1;
            bwd = row;
            bwd.head = {1'b0, chk};
            done_next     = 1'b1;
            status_next   = htoc_pkg::STAT_OK;
            location_next = chk_loc;
            found_next    = '0;
            acc_out_next  = acc_inc;
            state_next    = ST_IDLE;
          end else if (chk == LAST_REC) begin
            done_next     = 1'b1;
            status_next   = htoc_pkg::STAT_POOL_FULL;
            location_next = '0;
            found_next    = '0;
            acc_out_next  = acc_inc;
            state_next    = ST_IDLE;
          end
        end
      end

      ST_WISSUE: begin
        pra        = p[PW-1:0];
        state_next = ST_WCHK;
      end

      ST_WCHK: begin
        acc_next = acc_inc;
        if (pmem_q.valid && pmem_q.key == key_q) begin
          if (cmd_q == htoc_pkg::CMD_SEARCH) begin
            done_next     = 1'b1;
            status_next   = htoc_pkg::STAT_OK;
            location_next = rec_loc;
            found_next    = pmem_q.val;
            acc_out_next  = acc_inc;
            state_next    = ST_IDLE;
          end else begin
            // Free the record, then relink around it
            pwe = 1'b1;
            pwa = p[PW-1:0];
            pwd = pmem_q;
            pwd.valid = 1'b0;
            nxt_q_next = pmem_q.nxt;
            state_next = ST_UNLINK;
          end
        end else begin
          prev_next     = p;
          prev_rec_next = pmem_q;
          p_next        = pmem_q.nxt;
          w_next        = w_inc;
          if (w_inc == POOL_N || pmem_q.nxt >= POOL_N) begin
            done_next     = 1'b1;
            status_next   = htoc_pkg::STAT_NOT_FOUND;
            location_next = '0;
            found_next    = '0;
            acc_out_next  = (cmd_q == htoc_pkg::CMD_SEARCH) ? acc_inc : '0;
            state_next    = ST_IDLE;
          end else begin
            state_next = ST_WISSUE;
          end
        end
      end

      ST_UNLINK: begin
        if (prev < POOL_N) begin
          pwe = 1'b1;
          pwa = prev[PW-1:0];
          pwd = prev_rec;
          pwd.nxt = nxt_q;
        end else begin
          bwe = 1'b1;
          bwd = row;
          bwd.head = nxt_q;
        end
        done_next     = 1'b1;
        status_next   = htoc_pkg::STAT_OK;
        location_next = rec_loc;
        found_next    = '0;
        acc_out_next  = '0;
        state_next    = ST_IDLE;
      end

      ST_DREF: begin
        pra        = row.head[PW-1:0];
        state_next = ST_DREFC;
      end

      ST_DREFC: begin
        bwe = 1'b1;
        bwd = row;
        bwd.slots[sidx].key = pmem_q.key;
        bwd.slots[sidx].val = pmem_q.val;
        bwd.head = pmem_q.nxt;
        pwe = 1'b1;
        pwa = row.head[PW-1:0];
        pwd = pmem_q;
        pwd.valid = 1'b0;
        done_next     = 1'b1;
        status_next   = htoc_pkg::STAT_OK;
        location_next = slot_loc;
        found_next    = '0;
        acc_out_next  = '0;
        state_next    = ST_IDLE;
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_CLEAR;
      clr    <= '0;
      done   <= 1'b0;
      chk_ok <= 1'b0;
    end else begin
      state  <= state_next;
      clr    <= clr_next;
      done   <= done_next;
      chk_ok <= chk_ok_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cmd_q       <= cmd_next;
    key_q       <= key_next;
    val_q       <= val_next;
    prod        <= prod_next;
    bucket      <= bucket_next;
    row         <= row_next;
    sidx        <= sidx_next;
    acc         <= acc_next;
    iss         <= iss_next;
    chk         <= chk_next;
    p           <= p_next;
    prev        <= prev_next;
    prev_rec    <= prev_rec_next;
    nxt_q       <= nxt_q_next;
    w           <= w_next;
    status      <= status_next;
    location    <= location_next;
    found_value <= found_next;
    accesses    <= acc_out_next;
  end

  `HTOC_ASSERT_NOW(a_done_idle, done, !busy, "result strobe while still busy")
  `HTOC_ASSERT_NEXT(a_start_busy, start && !busy, busy && !done, "accepted item did not run")
  `HTOC_ASSERT_NOW(a_miss_zero, done && status != htoc_pkg::STAT_OK, location == '0 && found_value == '0, "miss result carries data")
  `HTOC_ASSERT_NOW(a_delete_acc, done && cmd_q == htoc_pkg::CMD_DELETE, accesses == '0, "delete reported accesses")

endmodule
